// ===== hdl/light_gun_beam_latch_and_serial_report_defines.svh =====
// ----------------------------------------------------------------------------
// light gun beam latch and serial report: assertion macros
// shared assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef LIGHT_GUN_BEAM_LATCH_AND_SERIAL_REPORT_DEFINES_SVH
`define LIGHT_GUN_BEAM_LATCH_AND_SERIAL_REPORT_DEFINES_SVH

// same-cycle implication
`define LGB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lgb_pkg.sv =====
// ----------------------------------------------------------------------------
// lgb_pkg
// types and constants shared by the light gun beam latch and report block
// ----------------------------------------------------------------------------
package lgb_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LATCH = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int LINE_CLOCKS  = 1364;
	localparam int X_BIAS       = 24;
	localparam int CLAMP_LOW    = -16;
	localparam int CLAMP_X_HIGH = 256 + 16;
	localparam int CLAMP_Y_HIGH = 240 + 16;
	localparam int SCREEN_WIDTH = 256;

	localparam logic [7:0] VISIBLE_LINES_RST = 8'd224;
	localparam logic signed [9:0] CURSOR_X_RST = 10'sd128;
	localparam logic signed [9:0] CURSOR_Y_RST = 10'sd120;

	localparam logic [3:0] REPORT_BITS = 4'd8;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [8:0]        beam_line;
		logic [10:0]       beam_dot;
		logic signed [8:0] aim_dx;
		logic signed [8:0] aim_dy;
		logic              latch_level;
		logic              trigger_pressed;
		logic              cursor_pressed;
		logic              turbo_pressed;
		logic              pause_pressed;
	} item_t;

	typedef struct packed {
		logic offscreen_q;
		logic offscreen_now;
	} beam_status_t;

	typedef struct packed {
		logic sample;
	} rpt_ctl_t;

endpackage

// ===== hdl/lgb_beam.sv =====
// ----------------------------------------------------------------------------
// lgb_beam
// beam position tracking, counter strobe and cursor update at frame wrap
// ----------------------------------------------------------------------------
module lgb_beam (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  lgb_pkg::item_t       item,
	input  logic [7:0]           visible_lines,
	input  lgb_pkg::rpt_ctl_t    rpt_ctl,
	output logic                 strobe,
	output lgb_pkg::beam_status_t status
);

	localparam logic signed [21:0] LINE_S   = 22'(lgb_pkg::LINE_CLOCKS);
	localparam logic signed [21:0] BIAS_S   = 22'(lgb_pkg::X_BIAS);
	localparam logic signed [10:0] LOW_S    = 11'(lgb_pkg::CLAMP_LOW);
	localparam logic signed [10:0] X_HIGH_S = 11'(lgb_pkg::CLAMP_X_HIGH);
	localparam logic signed [10:0] Y_HIGH_S = 11'(lgb_pkg::CLAMP_Y_HIGH);
	localparam logic signed [9:0]  WIDTH_S  = 10'(lgb_pkg::SCREEN_WIDTH);

	logic signed [9:0]  cursor_x_q;
	logic signed [9:0]  cursor_y_q;
	logic               offscreen_q;
	logic [18:0]        prev_pos_q;

	logic [19:0]        pos_next;
	logic signed [21:0] pos_s;
	logic signed [21:0] prev_s;
	logic signed [21:0] target;
	logic               is_tick;
	logic               wrap;
	logic signed [10:0] sum_x;
	logic signed [10:0] sum_y;
	logic signed [9:0]  new_x;
	logic signed [9:0]  new_y;

	function automatic logic off_calc(input logic signed [9:0] x, input logic signed [9:0] y,
			input logic [7:0] vl);
		logic signed [9:0] vl_s;
		vl_s = signed'({2'b00, vl});
		return (x < 10'sd0) || (y < 10'sd0) || (x >= WIDTH_S) || (y >= vl_s);
	endfunction

	function automatic logic signed [9:0] clamp10(input logic signed [10:0] v,
			input logic signed [10:0] hi);
		logic signed [10:0] r;
		if (v < LOW_S) begin
			r = LOW_S;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r[9:0];
	endfunction

	always_comb begin
		is_tick  = (item.opcode == lgb_pkg::OP_TICK);
		pos_next = 20'(item.beam_line) * 20'(lgb_pkg::LINE_CLOCKS) + 20'(item.beam_dot);
		pos_s    = signed'({2'b00, pos_next});
		prev_s   = signed'({3'b000, prev_pos_q});
		target   = 22'(cursor_y_q) * LINE_S + ((22'(cursor_x_q) + BIAS_S) <<< 2);
		strobe   = is_tick && !offscreen_q && (pos_s >= target) && (prev_s < target);
		wrap     = pos_next < {1'b0, prev_pos_q};
		sum_x    = 11'(item.aim_dx) + 11'(cursor_x_q);
		sum_y    = 11'(item.aim_dy) + 11'(cursor_y_q);
		new_x    = clamp10(sum_x, X_HIGH_S);
		new_y    = clamp10(sum_y, Y_HIGH_S);
		status.offscreen_q   = offscreen_q;
		status.offscreen_now = off_calc(cursor_x_q, cursor_y_q, visible_lines);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= lgb_pkg::CURSOR_X_RST;
			cursor_y_q  <= lgb_pkg::CURSOR_Y_RST;
			offscreen_q <= 1'b0;
			prev_pos_q  <= '0;
		end else if (fire) begin
			if (is_tick) begin
				prev_pos_q <= pos_next[18:0];
				if (wrap) begin
					cursor_x_q  <= new_x;
					cursor_y_q  <= new_y;
					offscreen_q <= off_calc(new_x, new_y, visible_lines);
				end
			end else if (rpt_ctl.sample) begin
				offscreen_q <= status.offscreen_now;
			end
		end
	end

endmodule

// ===== hdl/lgb_report.sv =====
// ----------------------------------------------------------------------------
// lgb_report
// latch handling, button sampling and serial report bit selection
// ----------------------------------------------------------------------------
module lgb_report (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  lgb_pkg::item_t        item,
	input  lgb_pkg::beam_status_t status,
	output logic                  data_bit,
	output lgb_pkg::rpt_ctl_t     rpt_ctl
);

	logic [3:0] bit_idx_q;
	logic       latch_q;
	logic       turbo_prev_q;
	logic       turbo_mode_q;
	logic       trigger_hold_q;
	logic       pause_report_q;
	logic       pause_hold_q;
	logic       cursor_held_q;

	logic       is_read;
	logic       is_latch;
	logic       turbo_mode_n;
	logic       trigger_rep_n;
	logic       pause_rep_n;
	logic       bit_sel;

	always_comb begin
		is_read        = (item.opcode == lgb_pkg::OP_READ);
		is_latch       = (item.opcode == lgb_pkg::OP_LATCH);
		rpt_ctl.sample = is_read && (bit_idx_q == 4'd0);
		turbo_mode_n   = turbo_mode_q ^ (item.turbo_pressed && !turbo_prev_q);
		trigger_rep_n  = item.trigger_pressed && (turbo_mode_n || !trigger_hold_q);
		pause_rep_n    = item.pause_pressed && !pause_hold_q;
		unique case (bit_idx_q)
			4'd0:    bit_sel = trigger_rep_n && !status.offscreen_now;
			4'd1:    bit_sel = cursor_held_q;
			4'd2:    bit_sel = turbo_mode_q;
			4'd3:    bit_sel = pause_report_q;
			4'd4:    bit_sel = 1'b0;
			4'd5:    bit_sel = 1'b0;
			4'd6:    bit_sel = status.offscreen_q;
			4'd7:    bit_sel = 1'b0;
			default: bit_sel = 1'b1;
		endcase
		data_bit = is_read && bit_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_idx_q        <= '0;
			latch_q          <= 1'b0;
			turbo_prev_q     <= 1'b0;
			turbo_mode_q     <= 1'b0;
			trigger_hold_q   <= 1'b0;
			pause_report_q   <= 1'b0;
			pause_hold_q     <= 1'b0;
			cursor_held_q    <= 1'b0;
		end else if (fire) begin
			if (is_latch && (item.latch_level != latch_q)) begin
				latch_q   <= item.latch_level;
				bit_idx_q <= '0;
			end
			if (is_read) begin
				bit_idx_q <= (bit_idx_q < lgb_pkg::REPORT_BITS) ? bit_idx_q + 4'd1
					: lgb_pkg::REPORT_BITS;
			end
			if (rpt_ctl.sample) begin
				turbo_prev_q     <= item.turbo_pressed;
				turbo_mode_q     <= turbo_mode_n;
				trigger_hold_q   <= item.trigger_pressed;
				pause_report_q   <= pause_rep_n;
				pause_hold_q     <= item.pause_pressed;
				cursor_held_q    <= item.cursor_pressed;
			end
		end
	end

endmodule

// ===== hdl/light_gun_beam_latch_and_serial_report.sv =====
// ----------------------------------------------------------------------------
// light_gun_beam_latch_and_serial_report
// light gun controller: beam latch strobe and serial button report
// ----------------------------------------------------------------------------
// usage
//   s_* stream carries one item per transfer: s_tuser is the opcode (tick,
//   latch write, data read), s_tdata holds beam position, aim deltas, latch
//   level and button levels. m_* stream returns exactly one result per item
//   with the report bit and the counter strobe.
//   visible_lines is written over the apb port at address 0; pready is always
//   high. The user writes it only while the block is idle; it is not checked.
// timing
//   an item is registered on input, evaluated combinationally and the result
//   is registered on output together with m_tvalid.
//   one item per cycle sustained while m_tready is high; the output register
//   and the input register together decouple the two sides.
// reset
//   arst_n clears all state: cursor at 128,120, report counter at bit 0,
//   visible_lines 224, both streams empty.
// stall
//   with m_tready low the result holds, one more item is taken into the input
//   register and s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
`include "light_gun_beam_latch_and_serial_report_defines.svh"

module light_gun_beam_latch_and_serial_report (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// beam_line, beam_dot, aim_dx, aim_dy, latch_level, trigger_pressed,
	// cursor_pressed, turbo_pressed, pause_pressed, zero fill
	input  logic [47:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// data_bit, counter_strobe, zero fill
	output logic [7:0]  m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lgb_pkg::item_t        item_in;
	lgb_pkg::item_t        item_s1;
	logic                  valid_s1;
	logic                  out_valid_q;
	logic [1:0]            out_data_q;
	logic [7:0]            visible_lines_q;
	logic                  adv;
	logic                  strobe;
	logic                  data_bit;
	lgb_pkg::beam_status_t status;
	lgb_pkg::rpt_ctl_t     rpt_ctl;

	always_comb begin
		item_in.opcode          = s_tuser;
		item_in.beam_line       = s_tdata[8:0];
		item_in.beam_dot        = s_tdata[19:9];
		item_in.aim_dx          = signed'(s_tdata[28:20]);
		item_in.aim_dy          = signed'(s_tdata[37:29]);
		item_in.latch_level     = s_tdata[38];
		item_in.trigger_pressed = s_tdata[39];
		item_in.cursor_pressed  = s_tdata[40];
		item_in.turbo_pressed   = s_tdata[41];
		item_in.pause_pressed   = s_tdata[42];
	end

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_data_q};
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? {24'b0, visible_lines_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_lines_q <= lgb_pkg::VISIBLE_LINES_RST;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			visible_lines_q <= pwdata[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
		if (adv) begin
			out_data_q <= {strobe, data_bit};
		end
	end

	lgb_beam u_beam (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (adv),
		.item          (item_s1),
		.visible_lines (visible_lines_q),
		.rpt_ctl       (rpt_ctl),
		.strobe        (strobe),
		.status        (status)
	);

	lgb_report u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (adv),
		.item     (item_s1),
		.status   (status),
		.data_bit (data_bit),
		.rpt_ctl  (rpt_ctl)
	);

	`LGB_ASSERT_NOW(a_full_blocks, valid_s1 && out_valid_q && !m_tready, !s_tready, "input taken while both stages full")
	`LGB_ASSERT_NEXT(a_adv_fills, adv, out_valid_q, "advanced item produced no result")
	`LGB_ASSERT_NEXT(a_strobe_tick, adv && (item_s1.opcode != lgb_pkg::OP_TICK), !out_data_q[1], "strobe on non-tick item")
	`LGB_ASSERT_NEXT(a_bit_read, adv && (item_s1.opcode != lgb_pkg::OP_READ), !out_data_q[0], "data bit on non-read item")

endmodule
